// File: rtl/core/square_of_matrix_difference_macros.svh
// Assertion macros for the square_of_matrix_difference checker.
`ifndef SQUARE_OF_MATRIX_DIFFERENCE_MACROS_SVH
`define SQUARE_OF_MATRIX_DIFFERENCE_MACROS_SVH

// Check on every rising edge outside reset.
`define SQMD_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("%m: assertion failed");

// Check on every rising edge, reset included.
`define SQMD_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("%m: assertion failed");

`endif

// File: rtl/core/sqmd_pkg.sv
// Shared types and constants of the square of matrix difference block.
package sqmd_pkg;

   localparam int MAX_SIZE = 8;
   localparam int IDX_W    = $clog2(MAX_SIZE);
   localparam int ADDR_W   = 2 * IDX_W;
   localparam int DEPTH    = MAX_SIZE * MAX_SIZE;
   localparam int DATA_W   = 32;
   localparam int SIZE_W   = 4;
   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_SIZE);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUB,
      ST_MAC,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic [ADDR_W-1:0] rd_addr_a;
      logic [ADDR_W-1:0] rd_addr_b;
   } ram_req_type;

   typedef struct packed {
      logic issue;
      logic clear;
   } mac_ctrl_type;

endpackage

// File: rtl/core/square_of_matrix_difference.sv
// Top level of the square of matrix difference block.
//
//   channel  ports                                    direction  transfer when
//   req      req_valid, req_stall, req_value           in         valid && !stall
//   rsp      rsp_valid, rsp_stall, rsp_element, ...    out        valid && !stall
//   csr      csr_valid, csr_ready, csr_matrix_size     in         valid && ready
//
// An element of A is written directly; an element of B also passes through ST_SUB,
// for the read-modify-write of the difference through the store's single write port.
// Each result of D*D takes n multiply-accumulates in ST_MAC, a wait in ST_DRAIN for the
// read, product and accumulator registers, and a load of the result register in ST_EMIT;
// req stays stalled for the whole burst after the last B element, longer if rsp stalls.
// Reset is synchronous and sets the size to 8; req stalls while csr is offered.
module square_of_matrix_difference (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [sqmd_pkg::DATA_W-1:0]  req_value,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sqmd_pkg::SIZE_W-1:0]         csr_matrix_size,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [sqmd_pkg::DATA_W-1:0]  rsp_element,
   output logic [sqmd_pkg::IDX_W-1:0]          rsp_row,
   output logic [sqmd_pkg::IDX_W-1:0]          rsp_col,
   output logic                                rsp_row_not_dominant,
   output logic                                rsp_last
);

   sqmd_pkg::ram_req_type        ram_req;
   sqmd_pkg::mac_ctrl_type       mac_ctrl;
   logic [sqmd_pkg::DATA_W-1:0]  rd_data_a;
   logic [sqmd_pkg::DATA_W-1:0]  rd_data_b;
   logic [sqmd_pkg::DATA_W-1:0]  acc;
   logic                         mac_busy;

   sqmd_ctrl u_ctrl (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_value            (req_value),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_matrix_size      (csr_matrix_size),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_element          (rsp_element),
      .rsp_row              (rsp_row),
      .rsp_col              (rsp_col),
      .rsp_row_not_dominant (rsp_row_not_dominant),
      .rsp_last             (rsp_last),
      .ram_req              (ram_req),
      .rd_data_a            (rd_data_a),
      .mac_ctrl             (mac_ctrl),
      .mac_busy             (mac_busy),
      .acc                  (acc)
   );

   sqmd_ram u_ram (
      .clock     (clock),
      .ram_req   (ram_req),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   sqmd_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .mac_ctrl  (mac_ctrl),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .acc       (acc),
      .busy      (mac_busy)
   );

endmodule

// File: rtl/core/sqmd_ram.sv
// Matrix store: one write port, two registered read ports.
module sqmd_ram (
   input  logic                         clock,
   input  sqmd_pkg::ram_req_type        ram_req,
   output logic [sqmd_pkg::DATA_W-1:0]  rd_data_a,
   output logic [sqmd_pkg::DATA_W-1:0]  rd_data_b
);

   logic [sqmd_pkg::DATA_W-1:0] mem [sqmd_pkg::DEPTH];
   logic [sqmd_pkg::DATA_W-1:0] rd_data_a_ff;
   logic [sqmd_pkg::DATA_W-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      rd_data_a_ff <= mem[ram_req.rd_addr_a];
      rd_data_b_ff <= mem[ram_req.rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// File: rtl/core/sqmd_mac.sv
// Multiply-accumulate pipeline: product register, then accumulator.
module sqmd_mac (
   input  logic                         clock,
   input  logic                         reset,
   input  sqmd_pkg::mac_ctrl_type       mac_ctrl,
   input  logic [sqmd_pkg::DATA_W-1:0]  rd_data_a,
   input  logic [sqmd_pkg::DATA_W-1:0]  rd_data_b,
   output logic [sqmd_pkg::DATA_W-1:0]  acc,
   output logic                         busy
);

   logic                           vld1_ff;
   logic                           vld2_ff;
   logic [sqmd_pkg::DATA_W-1:0]    prod_in;
   logic [sqmd_pkg::DATA_W-1:0]    prod_ff;
   logic [sqmd_pkg::DATA_W-1:0]    acc_in;
   logic [sqmd_pkg::DATA_W-1:0]    acc_ff;

   // low word of the product is the wrapped result
   assign prod_in = rd_data_a * rd_data_b;

   always_comb begin
      acc_in = acc_ff;
      if (mac_ctrl.clear) begin
         acc_in = '0;
      end else if (vld2_ff) begin
         acc_in = acc_ff + prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else begin
         vld1_ff <= mac_ctrl.issue;
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (vld1_ff) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
   end

   assign acc  = acc_ff;
   assign busy = vld1_ff | vld2_ff;

endmodule

// File: rtl/core/sqmd_ctrl.sv
// Sequencer: load of A and B, read-modify-write of D, product loop, result register.
module sqmd_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [sqmd_pkg::DATA_W-1:0]  req_value,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sqmd_pkg::SIZE_W-1:0]         csr_matrix_size,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [sqmd_pkg::DATA_W-1:0]  rsp_element,
   output logic [sqmd_pkg::IDX_W-1:0]          rsp_row,
   output logic [sqmd_pkg::IDX_W-1:0]          rsp_col,
   output logic                                rsp_row_not_dominant,
   output logic                                rsp_last,
   output sqmd_pkg::ram_req_type               ram_req,
   input  logic [sqmd_pkg::DATA_W-1:0]         rd_data_a,
   output sqmd_pkg::mac_ctrl_type              mac_ctrl,
   input  logic                                mac_busy,
   input  logic [sqmd_pkg::DATA_W-1:0]         acc
);

   sqmd_pkg::state_type                 state_ff, state_in;
   logic [sqmd_pkg::SIZE_W-1:0]         size_ff, size_in;
   logic                                phase_ff, phase_in;
   logic [sqmd_pkg::IDX_W-1:0]          row_ff, row_in;
   logic [sqmd_pkg::IDX_W-1:0]          col_ff, col_in;
   logic [sqmd_pkg::MAX_SIZE-1:0]       flags_ff, flags_in;
   logic signed [sqmd_pkg::DATA_W-1:0]  row_max_ff, row_max_in;
   logic signed [sqmd_pkg::DATA_W-1:0]  row_diag_ff, row_diag_in;
   logic                                last_b_ff, last_b_in;
   logic [sqmd_pkg::IDX_W-1:0]          i_ff, i_in;
   logic [sqmd_pkg::IDX_W-1:0]          j_ff, j_in;
   logic [sqmd_pkg::IDX_W-1:0]          s_ff, s_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [sqmd_pkg::DATA_W-1:0]         val_ff;
   logic [sqmd_pkg::ADDR_W-1:0]         waddr_ff;
   logic [sqmd_pkg::DATA_W-1:0]         rsp_element_ff;
   logic [sqmd_pkg::IDX_W-1:0]          rsp_row_ff;
   logic [sqmd_pkg::IDX_W-1:0]          rsp_col_ff;
   logic                                rsp_nd_ff;
   logic                                rsp_last_ff;

   logic [sqmd_pkg::SIZE_W-1:0]         n_eff;
   logic [sqmd_pkg::IDX_W-1:0]          nm1;
   logic                                col_last;
   logic                                row_last;
   logic                                req_take;
   logic                                b_take;
   logic                                rsp_load;
   logic signed [sqmd_pkg::DATA_W-1:0]  new_max;
   logic signed [sqmd_pkg::DATA_W-1:0]  new_diag;

   // clamp the configured size to 1..MAX_SIZE
   always_comb begin
      if (size_ff == '0) begin
         n_eff = sqmd_pkg::SIZE_W'(1);
      end else if (size_ff > sqmd_pkg::SIZE_W'(sqmd_pkg::MAX_SIZE)) begin
         n_eff = sqmd_pkg::SIZE_W'(sqmd_pkg::MAX_SIZE);
      end else begin
         n_eff = size_ff;
      end
   end

   assign nm1      = sqmd_pkg::IDX_W'(n_eff - sqmd_pkg::SIZE_W'(1));
   assign col_last = (col_ff == nm1);
   assign row_last = (row_ff == nm1);
   assign new_max  = (col_ff == '0 || req_value > row_max_ff) ? req_value : row_max_ff;
   assign new_diag = (col_ff == row_ff) ? req_value : row_diag_ff;

   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      phase_in     = phase_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      flags_in     = flags_ff;
      row_max_in   = row_max_ff;
      row_diag_in  = row_diag_ff;
      last_b_in    = last_b_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      s_in         = s_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_load     = 1'b0;
      req_take     = 1'b0;
      b_take       = 1'b0;
      // a size write takes the cycle; hold req off meanwhile
      req_stall    = (state_ff != sqmd_pkg::ST_IDLE) || csr_valid;
      csr_ready    = (state_ff == sqmd_pkg::ST_IDLE);

      ram_req.wr_en     = 1'b0;
      ram_req.wr_addr   = {row_ff, col_ff};
      ram_req.wr_data   = req_value;
      ram_req.rd_addr_a = {row_ff, col_ff};
      ram_req.rd_addr_b = {s_ff, j_ff};
      mac_ctrl.issue    = 1'b0;
      mac_ctrl.clear    = 1'b0;

      // drop the result register once it transfers
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         sqmd_pkg::ST_IDLE: begin
            if (csr_valid) begin
               size_in     = csr_matrix_size;
               phase_in    = 1'b0;
               row_in      = '0;
               col_in      = '0;
               flags_in    = '0;
               row_max_in  = '0;
               row_diag_in = '0;
            end else if (req_valid) begin
               req_take = 1'b1;
               if (col_last) begin
                  col_in = '0;
                  row_in = row_last ? '0 : row_ff + sqmd_pkg::IDX_W'(1);
               end else begin
                  col_in = col_ff + sqmd_pkg::IDX_W'(1);
               end
               if (!phase_ff) begin
                  ram_req.wr_en = 1'b1;
                  row_max_in    = new_max;
                  row_diag_in   = new_diag;
                  if (col_last && new_max > new_diag) begin
                     flags_in[row_ff] = 1'b1;
                  end
                  if (col_last && row_last) begin
                     phase_in = 1'b1;
                  end
               end else begin
                  // read A now, write the difference next cycle
                  b_take    = 1'b1;
                  last_b_in = col_last && row_last;
                  if (col_last && row_last) begin
                     phase_in = 1'b0;
                  end
                  state_in = sqmd_pkg::ST_SUB;
               end
            end
         end
         sqmd_pkg::ST_SUB: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = waddr_ff;
            ram_req.wr_data = rd_data_a - val_ff;
            if (last_b_ff) begin
               i_in     = '0;
               j_in     = '0;
               s_in     = '0;
               state_in = sqmd_pkg::ST_MAC;
            end else begin
               state_in = sqmd_pkg::ST_IDLE;
            end
         end
         sqmd_pkg::ST_MAC: begin
            ram_req.rd_addr_a = {i_ff, s_ff};
            ram_req.rd_addr_b = {s_ff, j_ff};
            mac_ctrl.issue    = 1'b1;
            mac_ctrl.clear    = (s_ff == '0);
            if (s_ff == nm1) begin
               s_in     = '0;
               state_in = sqmd_pkg::ST_DRAIN;
            end else begin
               s_in = s_ff + sqmd_pkg::IDX_W'(1);
            end
         end
         sqmd_pkg::ST_DRAIN: begin
            if (!mac_busy) begin
               state_in = sqmd_pkg::ST_EMIT;
            end
         end
         sqmd_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_load     = 1'b1;
               if (j_ff == nm1) begin
                  j_in = '0;
                  if (i_ff == nm1) begin
                     i_in        = '0;
                     flags_in    = '0;
                     row_max_in  = '0;
                     row_diag_in = '0;
                     state_in    = sqmd_pkg::ST_IDLE;
                  end else begin
                     i_in     = i_ff + sqmd_pkg::IDX_W'(1);
                     state_in = sqmd_pkg::ST_MAC;
                  end
               end else begin
                  j_in     = j_ff + sqmd_pkg::IDX_W'(1);
                  state_in = sqmd_pkg::ST_MAC;
               end
            end
         end
         default: begin
            state_in = sqmd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sqmd_pkg::ST_IDLE;
         size_ff      <= sqmd_pkg::SIZE_RESET;
         phase_ff     <= 1'b0;
         row_ff       <= '0;
         col_ff       <= '0;
         flags_ff     <= '0;
         row_max_ff   <= '0;
         row_diag_ff  <= '0;
         last_b_ff    <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         s_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         phase_ff     <= phase_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         flags_ff     <= flags_in;
         row_max_ff   <= row_max_in;
         row_diag_ff  <= row_diag_in;
         last_b_ff    <= last_b_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         s_ff         <= s_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && b_take) begin
         val_ff   <= req_value;
         waddr_ff <= {row_ff, col_ff};
      end
      if (rsp_load) begin
         rsp_element_ff <= acc;
         rsp_row_ff     <= i_ff;
         rsp_col_ff     <= j_ff;
         rsp_nd_ff      <= flags_ff[i_ff];
         rsp_last_ff    <= (i_ff == nm1) && (j_ff == nm1);
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_element          = rsp_element_ff;
   assign rsp_row              = rsp_row_ff;
   assign rsp_col              = rsp_col_ff;
   assign rsp_row_not_dominant = rsp_nd_ff;
   assign rsp_last             = rsp_last_ff;

endmodule

// File: rtl/core/sqmd_checker.sv
// Port-level checker for the square of matrix difference block, with its bind.
`include "square_of_matrix_difference_macros.svh"

module sqmd_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic signed [sqmd_pkg::DATA_W-1:0]  rsp_element,
   input  logic [sqmd_pkg::IDX_W-1:0]          rsp_row,
   input  logic [sqmd_pkg::IDX_W-1:0]          rsp_col,
   input  logic                                rsp_row_not_dominant,
   input  logic                                rsp_last
);

   // a stalled result holds
   `SQMD_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_element) && $stable(rsp_row) && $stable(rsp_col) && $stable(rsp_row_not_dominant) && $stable(rsp_last))

   // the final element sits on the diagonal
   `SQMD_ASSERT(a_last_diag, rsp_valid && rsp_last |-> rsp_row == rsp_col)

   // a size write and a request never transfer in the same cycle
   `SQMD_ASSERT(a_one_transfer, csr_valid && csr_ready |-> !(req_valid && !req_stall))

   // mid-burst the request side stays stalled
   `SQMD_ASSERT(a_burst_stall, rsp_valid && !rsp_last |-> req_stall)

   // reset empties the result register
   `SQMD_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid)

endmodule

bind square_of_matrix_difference sqmd_checker u_sqmd_checker (.*);
